[src/tpc_pkg.sv]
// types, status codes and crc helper shared by the tensor payload checker
package tpc_pkg;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES       = 32'hFFFF_FFFF;
    localparam logic signed [15:0] EXP_MIN = -16'sd300;
    localparam logic signed [15:0] EXP_MAX = 16'sd300;
    localparam logic [7:0] FORBIDDEN_CODE  = 8'h80;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EXPONENT = 2'd1;
    localparam status_t ST_CODE     = 2'd2;
    localparam status_t ST_CRC      = 2'd3;

    localparam int REG_ADDR_BITS = 4;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_EXP_GROUPS   = 2'd0;
    localparam reg_index_t REG_CODE_ELEMS   = 2'd1;
    localparam reg_index_t REG_EXPECTED_CRC = 2'd2;

    // reflected crc-32, one byte folded in, eight bit steps unrolled
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

[src/tensor_payload_checker_top.sv]
// tensor payload checker: crc-32 and range checks over a streamed payload
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid / in_stall    | payload_byte, start_req
//  out     | output    | out_valid / out_stall  | status, computed_crc
//  cfg     | input     | apb psel/penable/...   | exponent_groups, code_elements,
//          |           |                        | expected_crc
//
// one word per cycle sustained while no held result blocks on out_stall; a word
// passes an input register, then the byte-wide crc update and checks land in
// the state and result registers, and the result register takes its last byte's result.
// reset sets config, valid and payload state, not the data registers; no clearing pass is needed.
// the input register takes one more word while a result waits on out_stall;
// after that in_stall holds until the result is taken.
module tensor_payload_checker_top
    import tpc_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               payload_byte,
    input  logic                     start_req,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [31:0]              computed_crc,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [REG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int SEEN_W = COUNT_BITS + 2;

    // configuration registers
    logic [31:0] exp_groups_reg;
    logic [31:0] code_elems_reg;
    logic [31:0] expected_crc_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // payload state
    logic [31:0]       crc_reg;
    logic [31:0]       crc_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [7:0]        low_byte_reg;
    logic [7:0]        low_byte_next;
    status_t           err_reg;
    status_t           err_next;
    logic              active_reg;

    // result register
    logic              out_valid_reg;
    status_t           status_reg;
    logic [31:0]       crc_out_reg;

    logic              cfg_write;
    reg_index_t        cfg_index;
    logic              advance;
    logic              live;
    logic [31:0]       base_crc;
    logic [SEEN_W-1:0] pos;
    status_t           base_err;
    logic [7:0]        base_low;
    logic [SEEN_W-1:0] exp_bytes;
    logic [SEEN_W-1:0] total;
    logic [SEEN_W-1:0] pos_inc;
    logic              is_exp;
    logic signed [15:0] exponent;
    status_t           found;
    logic              done;
    logic [31:0]       final_crc;
    status_t           final_status;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[REG_ADDR_BITS-1:2];
    assign pready    = 1'b1;

    always_comb
    begin
        case (cfg_index)
            REG_EXP_GROUPS:   prdata = exp_groups_reg;
            REG_CODE_ELEMS:   prdata = code_elems_reg;
            REG_EXPECTED_CRC: prdata = expected_crc_reg;
            default:          prdata = 32'd0;
        endcase
    end

    // the processing step moves when the input register holds a word, unless a finished result is held back
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        live      = in_start_reg || active_reg;
        base_crc  = in_start_reg ? CRC_ONES : crc_reg;
        pos       = in_start_reg ? '0 : seen_reg;
        base_err  = in_start_reg ? ST_OK : err_reg;
        base_low  = in_start_reg ? 8'd0 : low_byte_reg;

        exp_bytes = {1'b0, exp_groups_reg[COUNT_BITS-1:0], 1'b0};
        total     = exp_bytes + {2'b00, code_elems_reg[COUNT_BITS-1:0]};
        pos_inc   = pos + SEEN_W'(1);
        is_exp    = pos < exp_bytes;

        crc_next      = crc_byte(base_crc, in_byte_reg);
        low_byte_next = base_low;
        exponent      = {in_byte_reg, base_low};
        found         = ST_OK;
        if (is_exp)
        begin
            if (!pos[0])
            begin
                low_byte_next = in_byte_reg;
            end
            else if (exponent < EXP_MIN || exponent > EXP_MAX)
            begin
                found = ST_EXPONENT;
            end
        end
        else if (in_byte_reg == FORBIDDEN_CODE)
        begin
            found = ST_CODE;
        end

        // first error in stream order wins
        err_next  = (base_err == ST_OK) ? found : base_err;
        seen_next = pos_inc;
        done      = !(pos_inc < total);

        final_crc    = crc_next ^ CRC_ONES;
        final_status = err_next;
        if (err_next == ST_OK && final_crc != expected_crc_reg)
        begin
            final_status = ST_CRC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_groups_reg   <= 32'd1;
            code_elems_reg   <= 32'd1;
            expected_crc_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_EXP_GROUPS:   exp_groups_reg   <= pwdata;
                REG_CODE_ELEMS:   code_elems_reg   <= pwdata;
                REG_EXPECTED_CRC: expected_crc_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg  <= payload_byte;
            in_start_reg <= start_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= CRC_ONES;
            seen_reg     <= '0;
            low_byte_reg <= 8'd0;
            err_reg      <= ST_OK;
            active_reg   <= 1'b0;
        end
        else if (advance && live)
        begin
            crc_reg      <= crc_next;
            seen_reg     <= seen_next;
            low_byte_reg <= low_byte_next;
            err_reg      <= err_next;
            active_reg   <= !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && live && done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && live && done)
        begin
            status_reg  <= final_status;
            crc_out_reg <= final_crc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign computed_crc = crc_out_reg;

    // a new result only comes from a step that finished a payload
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && live && done))
        else $error("result without a completing step");

    // a word outside any payload leaves no result behind
    a_idle_word_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !active_reg && !in_start_reg) |=> !out_valid_reg)
        else $error("idle word produced a result");

    // the input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a held result");

    // a completed payload always leaves the checker idle
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && live && done) |=> !active_reg)
        else $error("checker still active after completion");

endmodule
